>>> rtl/gradient_noise_2d_sampler_core_assert.svh
// Assertion helpers for the gradient noise sampler.
// Both expect clk and arst_n in the scope where they are used.
`ifndef GRADIENT_NOISE_2D_SAMPLER_CORE_ASSERT_SVH
`define GRADIENT_NOISE_2D_SAMPLER_CORE_ASSERT_SVH

// same-cycle implication
`define GN2D_ASSERT_NOW(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication
`define GN2D_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

>>> rtl/gn2d_pkg.sv
`default_nettype none

package gn2d_pkg;

	localparam int FRAC_BITS        = 8;
	localparam int COORD_W          = 12;
	localparam int CELL_W           = COORD_W - FRAC_BITS;
	localparam int SIZE_W           = 5;
	localparam int IDX_IN_W         = 4;
	localparam int GRAD_W           = 16;
	localparam int Q_ONE            = 16384;
	localparam int CFG_RESET_SIZE   = 16;
	localparam int DEF_GRID_COLUMNS = 16;
	localparam int DEF_GRID_ROWS    = 16;
	localparam int NUM_BANKS        = 4;
	localparam int CFG_IDX_W        = 1;

	typedef enum logic {
		MODE_EVAL  = 1'b0,
		MODE_WRITE = 1'b1
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GRID_WIDTH  = 1'b0,
		CFG_GRID_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic signed [GRAD_W-1:0] gx;
		logic signed [GRAD_W-1:0] gy;
	} grad_t;

	// per-sample info handed from address stage to the blend pipe
	typedef struct packed {
		logic [FRAC_BITS-1:0] fx;
		logic [FRAC_BITS-1:0] fy;
		logic                 x_par;
		logic                 y_par;
		logic                 far_x_ok;
		logic                 far_y_ok;
		logic                 clamped;
	} samp_t;

	// entries per parity bank
	function automatic int bank_depth(int cols, int rows);
		return ((cols + 1) >> 1) * ((rows + 1) >> 1);
	endfunction

	function automatic int addr_w(int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

endpackage

`default_nettype wire

>>> rtl/gn2d_ram.sv
`default_nettype none

module gn2d_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = gn2d_pkg::addr_w(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

>>> rtl/gn2d_front.sv
`default_nettype none

// Clamps the point, splits cell/fraction, steers the four corner reads
// to the parity banks and decodes gradient writes.
module gn2d_front #(
	parameter int GRID_COLUMNS = gn2d_pkg::DEF_GRID_COLUMNS,
	parameter int GRID_ROWS    = gn2d_pkg::DEF_GRID_ROWS,
	localparam int BANK_COLS   = (GRID_COLUMNS + 1) >> 1,
	localparam int BANK_AW     = gn2d_pkg::addr_w(gn2d_pkg::bank_depth(GRID_COLUMNS, GRID_ROWS))
) (
	input  wire logic                                take,
	input  wire logic                                mode,
	input  wire logic        [gn2d_pkg::COORD_W-1:0] x_coord,
	input  wire logic        [gn2d_pkg::COORD_W-1:0] y_coord,
	input  wire logic       [gn2d_pkg::IDX_IN_W-1:0] grad_column,
	input  wire logic       [gn2d_pkg::IDX_IN_W-1:0] grad_row,
	input  wire logic signed  [gn2d_pkg::GRAD_W-1:0] grad_x,
	input  wire logic signed  [gn2d_pkg::GRAD_W-1:0] grad_y,
	input  wire logic         [gn2d_pkg::SIZE_W-1:0] width_cfg,
	input  wire logic         [gn2d_pkg::SIZE_W-1:0] height_cfg,
	output logic           [gn2d_pkg::NUM_BANKS-1:0] rd_en,
	output logic                       [BANK_AW-1:0] rd_addr [gn2d_pkg::NUM_BANKS],
	output logic           [gn2d_pkg::NUM_BANKS-1:0] wr_en,
	output logic                       [BANK_AW-1:0] wr_addr,
	output gn2d_pkg::grad_t                          wr_data,
	output gn2d_pkg::samp_t                          samp
);

	localparam int F      = gn2d_pkg::FRAC_BITS;
	localparam int CW     = gn2d_pkg::CELL_W;
	localparam int SW     = gn2d_pkg::SIZE_W;
	localparam int XW     = gn2d_pkg::COORD_W;
	localparam int LIM_W  = SW + F;
	localparam int GW     = gn2d_pkg::GRAD_W;
	localparam logic signed [GW-1:0] G_POS = GW'(gn2d_pkg::Q_ONE);
	localparam logic signed [GW-1:0] G_NEG = -G_POS;

	// register value forced into [2, lim]
	function automatic logic [SW-1:0] used_size(logic [SW-1:0] r, int lim);
		if (r < SW'(2)) begin
			return SW'(2);
		end else if (32'(r) > lim) begin
			return SW'(lim);
		end else begin
			return r;
		end
	endfunction

	function automatic logic signed [GW-1:0] sat_grad(logic signed [GW-1:0] g);
		if (g > G_POS) begin
			return G_POS;
		end else if (g < G_NEG) begin
			return G_NEG;
		end else begin
			return g;
		end
	endfunction

	logic [SW-1:0]    w_used, h_used;
	logic [LIM_W-1:0] xlim, ylim;
	logic [XW-1:0]    x_c, y_c;
	logic             x_over, y_over;
	logic [CW-1:0]    x0, y0;
	logic [CW:0]      x0p1, y0p1;
	logic [CW:0]      col_sel [gn2d_pkg::NUM_BANKS];
	logic [CW:0]      row_sel [gn2d_pkg::NUM_BANKS];
	logic             is_eval, is_write, in_table;
	logic [1:0]       wr_bank;

	assign is_eval  = (mode == gn2d_pkg::MODE_EVAL);
	assign is_write = (mode == gn2d_pkg::MODE_WRITE);

	always_comb begin
		w_used = used_size(width_cfg, GRID_COLUMNS);
		h_used = used_size(height_cfg, GRID_ROWS);
		xlim   = {w_used - SW'(1), {F{1'b0}}};
		ylim   = {h_used - SW'(1), {F{1'b0}}};

		x_over = (LIM_W'(x_coord) > xlim);
		y_over = (LIM_W'(y_coord) > ylim);
		x_c    = x_over ? xlim[XW-1:0] : x_coord;
		y_c    = y_over ? ylim[XW-1:0] : y_coord;

		x0   = x_c[XW-1:F];
		y0   = y_c[XW-1:F];
		x0p1 = {1'b0, x0} + 1'b1;
		y0p1 = {1'b0, y0} + 1'b1;

		samp.fx       = x_c[F-1:0];
		samp.fy       = y_c[F-1:0];
		samp.x_par    = x0[0];
		samp.y_par    = y0[0];
		samp.far_x_ok = (SW'(x0p1) < w_used);
		samp.far_y_ok = (SW'(y0p1) < h_used);
		samp.clamped  = x_over | y_over;

		in_table = (32'(grad_column) < GRID_COLUMNS) && (32'(grad_row) < GRID_ROWS);
		wr_bank  = {grad_row[0], grad_column[0]};
		wr_addr  = BANK_AW'(32'(grad_row[gn2d_pkg::IDX_IN_W-1:1]) * BANK_COLS
			+ 32'(grad_column[gn2d_pkg::IDX_IN_W-1:1]));
		wr_data.gx = sat_grad(grad_x);
		wr_data.gy = sat_grad(grad_y);

		// bank {row parity, column parity}: each corner of a cell lands in a
		// different bank, so all four read in the same cycle
		for (int b = 0; b < gn2d_pkg::NUM_BANKS; b++) begin
			col_sel[b] = (x0[0] == b[0]) ? {1'b0, x0} : x0p1;
			row_sel[b] = (y0[0] == b[1]) ? {1'b0, y0} : y0p1;
			rd_addr[b] = BANK_AW'(32'(row_sel[b][CW:1]) * BANK_COLS + 32'(col_sel[b][CW:1]));
			rd_en[b]   = take && is_eval;
			wr_en[b]   = take && is_write && in_table && (wr_bank == 2'(b));
		end
	end

endmodule

`default_nettype wire

>>> rtl/gn2d_interp.sv
`default_nettype none

// Dot products, x blend, y blend, rounding and saturation.
// s1: bank data + sample info, s2: corner dots, s3: x blend sums,
// s4: rounded x blends, s5: y blend sum; result is combinational from s5.
module gn2d_interp (
	input  wire logic                               clk,
	input  wire logic                               en,
	input  wire gn2d_pkg::samp_t                    samp,
	input  wire gn2d_pkg::grad_t                    rd_data [gn2d_pkg::NUM_BANKS],
	output logic signed    [gn2d_pkg::GRAD_W-1:0]   noise,
	output logic                                    clamped
);

	localparam int F       = gn2d_pkg::FRAC_BITS;
	localparam int NB      = gn2d_pkg::NUM_BANKS;
	localparam int OFS_W   = F + 2;
	localparam int PROD_W  = OFS_W + gn2d_pkg::GRAD_W;
	localparam int DOT_W   = F + 17;
	localparam int BLEND_W = DOT_W + F;
	localparam int RES_W   = BLEND_W - 2 * F;
	localparam int WGT_W   = F + 1;

	localparam logic signed [OFS_W-1:0]   ONE_OFS = OFS_W'(1 << F);
	localparam logic        [WGT_W-1:0]   ONE_WGT = WGT_W'(1 << F);
	localparam logic signed [BLEND_W-1:0] HALF_X  = BLEND_W'(64'd1 << (F - 1));
	localparam logic signed [BLEND_W-1:0] HALF_Y  = BLEND_W'(64'd1 << (2 * F - 1));
	localparam logic signed [RES_W-1:0]   Q_POS   = RES_W'(gn2d_pkg::Q_ONE);
	localparam logic signed [RES_W-1:0]   Q_NEG   = -Q_POS;

	gn2d_pkg::samp_t          samp_s1;
	logic signed [DOT_W-1:0]  n_s2 [NB];
	logic [F-1:0]             fx_s2, fy_s2, fy_s3, fy_s4;
	logic                     cl_s2, cl_s3, cl_s4, cl_s5;
	logic signed [BLEND_W-1:0] ax_s3, bx_s3, v_s5;
	logic signed [DOT_W-1:0]  a_s4, b_s4;

	logic signed [OFS_W-1:0]  dx_near, dx_far, dy_near, dy_far;
	logic [1:0]               sel [NB];
	logic signed [PROD_W-1:0] prod_x [NB];
	logic signed [PROD_W-1:0] prod_y [NB];
	logic signed [DOT_W-1:0]  dot [NB];
	logic [WGT_W-1:0]         wx, wy;
	logic signed [BLEND_W-1:0] ax, bx, ar, br, vy, vr;
	logic signed [DOT_W-1:0]  a_rnd, b_rnd;
	logic signed [RES_W-1:0]  res;

	// corner c: bit 0 = far column, bit 1 = far row
	always_comb begin
		dx_near = $signed({2'b00, samp_s1.fx});
		dy_near = $signed({2'b00, samp_s1.fy});
		dx_far  = dx_near - ONE_OFS;
		dy_far  = dy_near - ONE_OFS;
		for (int c = 0; c < NB; c++) begin
			sel[c]    = {samp_s1.y_par ^ c[1], samp_s1.x_par ^ c[0]};
			prod_x[c] = (c[0] ? dx_far : dx_near) * rd_data[sel[c]].gx;
			prod_y[c] = (c[1] ? dy_far : dy_near) * rd_data[sel[c]].gy;
			dot[c]    = DOT_W'(prod_x[c] + prod_y[c]);
			// far corner past the last used edge carries zero weight
			if ((c[0] && !samp_s1.far_x_ok) || (c[1] && !samp_s1.far_y_ok)) begin
				dot[c] = '0;
			end
		end
	end

	always_comb begin
		wx = ONE_WGT - {1'b0, fx_s2};
		ax = $signed({1'b0, wx}) * n_s2[0] + $signed({2'b00, fx_s2}) * n_s2[1];
		bx = $signed({1'b0, wx}) * n_s2[2] + $signed({2'b00, fx_s2}) * n_s2[3];

		// round half up == arithmetic shift of (v + half)
		ar    = ax_s3 + HALF_X;
		br    = bx_s3 + HALF_X;
		a_rnd = DOT_W'(ar >>> F);
		b_rnd = DOT_W'(br >>> F);

		wy = ONE_WGT - {1'b0, fy_s4};
		vy = $signed({1'b0, wy}) * a_s4 + $signed({2'b00, fy_s4}) * b_s4;

		vr  = v_s5 + HALF_Y;
		res = RES_W'(vr >>> (2 * F));
		if (res > Q_POS) begin
			noise = gn2d_pkg::GRAD_W'(Q_POS);
		end else if (res < Q_NEG) begin
			noise = gn2d_pkg::GRAD_W'(Q_NEG);
		end else begin
			noise = gn2d_pkg::GRAD_W'(res);
		end
		clamped = cl_s5;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			samp_s1 <= samp;

			n_s2  <= dot;
			fx_s2 <= samp_s1.fx;
			fy_s2 <= samp_s1.fy;
			cl_s2 <= samp_s1.clamped;

			ax_s3 <= ax;
			bx_s3 <= bx;
			fy_s3 <= fy_s2;
			cl_s3 <= cl_s2;

			a_s4  <= a_rnd;
			b_s4  <= b_rnd;
			fy_s4 <= fy_s3;
			cl_s4 <= cl_s3;

			v_s5  <= vy;
			cl_s5 <= cl_s4;
		end
	end

endmodule

`default_nettype wire

>>> rtl/gradient_noise_2d_sampler_core.sv
// 2D gradient noise sampler (Perlin-style corner dots, linear blend, no fade).
// An item with mode = write stores one Q1.14 gradient (saturated to +-1) at
// (grad_row, grad_column) and returns nothing; writes outside the table are
// dropped. An item with mode = evaluate takes x/y with 8 fraction bits, clamps
// them to the used grid (point_clamped flags that), and returns one noise_value
// in Q1.14, saturated to +-1. Throughput is one item per clock in either mode
// when the output is not stalled; an evaluate result passes registers s1 to s5
// and the output register. The gradient table sits in four 1R1W banks split
// by column and row parity; the four corners of a cell read in the same cycle,
// and a far corner past the last used column or row has its dot zeroed.
// Writes commit at acceptance and only one item enters per cycle, so a read
// never overlaps a write of the same entry. The table has no reset and no
// clearing pass: evaluate only over entries that have been written. The
// configuration port (cfg_index 0 = used width, 1 = used height, each forced
// into [2, grid size]) is always ready; write it only while no item is in
// flight.
`default_nettype none

`include "gradient_noise_2d_sampler_core_assert.svh"

module gradient_noise_2d_sampler_core #(
	parameter int GRID_COLUMNS = gn2d_pkg::DEF_GRID_COLUMNS,
	parameter int GRID_ROWS    = gn2d_pkg::DEF_GRID_ROWS
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,

	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic                                 mode,
	input  wire logic         [gn2d_pkg::COORD_W-1:0] x_coord,
	input  wire logic         [gn2d_pkg::COORD_W-1:0] y_coord,
	input  wire logic        [gn2d_pkg::IDX_IN_W-1:0] grad_column,
	input  wire logic        [gn2d_pkg::IDX_IN_W-1:0] grad_row,
	input  wire logic signed   [gn2d_pkg::GRAD_W-1:0] grad_x,
	input  wire logic signed   [gn2d_pkg::GRAD_W-1:0] grad_y,

	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic signed        [gn2d_pkg::GRAD_W-1:0] noise_value,
	output logic                                      point_clamped,

	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic       [gn2d_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic          [gn2d_pkg::SIZE_W-1:0] cfg_data
);

	localparam int BANK_DEPTH = gn2d_pkg::bank_depth(GRID_COLUMNS, GRID_ROWS);
	localparam int BANK_AW    = gn2d_pkg::addr_w(BANK_DEPTH);
	localparam int NB         = gn2d_pkg::NUM_BANKS;

	// used grid size registers
	logic [gn2d_pkg::SIZE_W-1:0] width_q, height_q;

	// pipeline control: whole pipe moves when the output register is free
	// or being drained
	logic adv, take;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic out_valid_q;
	logic signed [gn2d_pkg::GRAD_W-1:0] noise_q;
	logic clamped_q;

	// bank ports
	logic [NB-1:0]      rd_en, wr_en;
	logic [BANK_AW-1:0] rd_addr [NB];
	logic [BANK_AW-1:0] wr_addr;
	gn2d_pkg::grad_t    wr_data;
	gn2d_pkg::grad_t    rd_data [NB];
	gn2d_pkg::samp_t    samp;

	logic signed [gn2d_pkg::GRAD_W-1:0] noise;
	logic clamped;

	assign adv       = !out_valid_q || out_ready;
	assign in_ready  = adv;
	assign take      = in_valid && adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= gn2d_pkg::SIZE_W'(gn2d_pkg::CFG_RESET_SIZE);
			height_q <= gn2d_pkg::SIZE_W'(gn2d_pkg::CFG_RESET_SIZE);
		end else if (cfg_valid && cfg_ready) begin
			unique case (gn2d_pkg::cfg_reg_t'(cfg_index))
				gn2d_pkg::CFG_GRID_WIDTH:  width_q  <= cfg_data;
				gn2d_pkg::CFG_GRID_HEIGHT: height_q <= cfg_data;
			endcase
		end
	end

	// address generation and write decode
	gn2d_front #(
		.GRID_COLUMNS (GRID_COLUMNS),
		.GRID_ROWS    (GRID_ROWS)
	) u_front (
		.take        (take),
		.mode        (mode),
		.x_coord     (x_coord),
		.y_coord     (y_coord),
		.grad_column (grad_column),
		.grad_row    (grad_row),
		.grad_x      (grad_x),
		.grad_y      (grad_y),
		.width_cfg   (width_q),
		.height_cfg  (height_q),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.samp        (samp)
	);

	// four parity banks; read data is the s1 register of the pipe and
	// holds during a stall because reads fire only on accepted items
	for (genvar b = 0; b < NB; b++) begin : g_bank
		gn2d_ram #(
			.WIDTH ($bits(gn2d_pkg::grad_t)),
			.DEPTH (BANK_DEPTH)
		) u_ram (
			.clk     (clk),
			.wr_en   (wr_en[b]),
			.wr_addr (wr_addr),
			.wr_data (wr_data),
			.rd_en   (rd_en[b]),
			.rd_addr (rd_addr[b]),
			.rd_data (rd_data[b])
		);
	end

	gn2d_interp u_interp (
		.clk     (clk),
		.en      (adv),
		.samp    (samp),
		.rd_data (rd_data),
		.noise   (noise),
		.clamped (clamped)
	);

	// valid tags follow evaluate items only; write items leave a bubble
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
			vld_s5      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s1      <= take && (mode == gn2d_pkg::MODE_EVAL);
			vld_s2      <= vld_s1;
			vld_s3      <= vld_s2;
			vld_s4      <= vld_s3;
			vld_s5      <= vld_s4;
			out_valid_q <= vld_s5;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (adv) begin
			noise_q   <= noise;
			clamped_q <= clamped;
		end
	end

	assign out_valid     = out_valid_q;
	assign noise_value   = noise_q;
	assign point_clamped = clamped_q;

	`GN2D_ASSERT_NOW(a_out_from_pipe, $rose(out_valid_q), $past(vld_s5), "result without a pipe item")
	`GN2D_ASSERT_NOW(a_one_bank_write, 1'b1, $onehot0(wr_en), "gradient write hit several banks")
	`GN2D_ASSERT_NEXT(a_stall_holds, !adv, $stable(vld_s1) && $stable(vld_s3) && $stable(vld_s5), "pipe moved while stalled")
	`GN2D_ASSERT_NOW(a_noise_range, out_valid_q, (noise_value <= gn2d_pkg::Q_ONE) && (noise_value >= -gn2d_pkg::Q_ONE), "noise outside +-1")

endmodule

`default_nettype wire

>>> test/testbench.sv
module testbench;

	import gn2d_pkg::*;

	// one item on the input channel
	typedef struct {
		mode_t                    mode;
		logic [COORD_W-1:0]       x;
		logic [COORD_W-1:0]       y;
		logic [IDX_IN_W-1:0]      col;
		logic [IDX_IN_W-1:0]      row;
		logic signed [GRAD_W-1:0] gx;
		logic signed [GRAD_W-1:0] gy;
	} sampler_item_t;

	// one result expected on the output channel
	typedef struct {
		logic signed [GRAD_W-1:0] noise;
		logic                     clamped;
	} noise_result_t;

	localparam int     TABLE_ENTRIES = DEF_GRID_COLUMNS * DEF_GRID_ROWS;
	localparam longint FRAC_ONE      = longint'(1) << FRAC_BITS;
	localparam int     PIPE_SETTLE   = 12;   // longer than the eval pipeline latency
	localparam int     MAX_IDLE      = 6;
	localparam int     PRINT_CAP     = 40;

	logic clk;
	logic arst_n = 1'b0;

	logic                     in_valid    = 1'b0;
	logic                     in_ready;
	logic                     mode        = MODE_EVAL;
	logic [COORD_W-1:0]       x_coord     = '0;
	logic [COORD_W-1:0]       y_coord     = '0;
	logic [IDX_IN_W-1:0]      grad_column = '0;
	logic [IDX_IN_W-1:0]      grad_row    = '0;
	logic signed [GRAD_W-1:0] grad_x      = '0;
	logic signed [GRAD_W-1:0] grad_y      = '0;

	logic                     out_valid;
	logic                     out_ready   = 1'b0;
	logic signed [GRAD_W-1:0] noise_value;
	logic                     point_clamped;

	logic                     cfg_valid   = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index   = CFG_GRID_WIDTH;
	logic [SIZE_W-1:0]        cfg_data    = '0;

	// shadow of the block: gradient table and raw register values
	int          grad_x_tab [TABLE_ENTRIES];
	int          grad_y_tab [TABLE_ENTRIES];
	logic [SIZE_W-1:0] grid_w_reg = SIZE_W'(CFG_RESET_SIZE);
	logic [SIZE_W-1:0] grid_h_reg = SIZE_W'(CFG_RESET_SIZE);

	sampler_item_t pending_items [$];
	noise_result_t noise_expected [$];
	sampler_item_t next_item;

	int  in_hold    = 0;
	int  out_hold   = 0;
	int  out_draw;
	bit  steady_in  = 1'b0;
	bit  steady_out = 1'b0;

	int  fail_count  = 0;
	int  evals_seen  = 0;
	int  writes_done = 0;
	int  grid_count  = 0;

	gradient_noise_2d_sampler_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.mode          (mode),
		.x_coord       (x_coord),
		.y_coord       (y_coord),
		.grad_column   (grad_column),
		.grad_row      (grad_row),
		.grad_x        (grad_x),
		.grad_y        (grad_y),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.noise_value   (noise_value),
		.point_clamped (point_clamped),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic logic signed [GRAD_W-1:0] sat_q14(longint v);
		if (v > Q_ONE)
			return GRAD_W'(Q_ONE);
		if (v < -Q_ONE)
			return GRAD_W'(-Q_ONE);
		return GRAD_W'(v);
	endfunction

	// divide by 2^s, ties go toward +inf
	function automatic longint round_half_up(longint v, int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	// register value forced into [2, limit]
	function automatic int eff_size(logic [SIZE_W-1:0] r, int limit);
		if (r < 2)
			return 2;
		if (r > limit)
			return limit;
		return int'(r);
	endfunction

	function automatic longint corner_dot(int cx, int cy, longint dx, longint dy);
		int idx;
		idx = cy * DEF_GRID_COLUMNS + cx;
		return dx * grad_x_tab[idx] + dy * grad_y_tab[idx];
	endfunction

	function automatic noise_result_t predict_noise(logic [COORD_W-1:0] xc,
			logic [COORD_W-1:0] yc);
		int w, h, xlim, ylim, x, y, x0, y0, x1, y1;
		longint fx, fy, n00, n10, n01, n11, a, b, v;
		noise_result_t r;
		w    = eff_size(grid_w_reg, DEF_GRID_COLUMNS);
		h    = eff_size(grid_h_reg, DEF_GRID_ROWS);
		xlim = (w - 1) << FRAC_BITS;
		ylim = (h - 1) << FRAC_BITS;
		x    = int'(xc);
		y    = int'(yc);
		r.clamped = 1'b0;
		// a coordinate beyond the used grid is pinned to the last grid line
		if (x > xlim) begin
			x = xlim;
			r.clamped = 1'b1;
		end
		if (y > ylim) begin
			y = ylim;
			r.clamped = 1'b1;
		end
		x0 = x >> FRAC_BITS;
		y0 = y >> FRAC_BITS;
		fx = x & (FRAC_ONE - 1);
		fy = y & (FRAC_ONE - 1);
		// on the last column/row the far corner folds back (its weight is zero)
		x1 = (x0 + 1 < w) ? x0 + 1 : x0;
		y1 = (y0 + 1 < h) ? y0 + 1 : y0;
		n00 = corner_dot(x0, y0, fx, fy);
		n10 = corner_dot(x1, y0, fx - FRAC_ONE, fy);
		n01 = corner_dot(x0, y1, fx, fy - FRAC_ONE);
		n11 = corner_dot(x1, y1, fx - FRAC_ONE, fy - FRAC_ONE);
		a = round_half_up((FRAC_ONE - fx) * n00 + fx * n10, FRAC_BITS);
		b = round_half_up((FRAC_ONE - fx) * n01 + fx * n11, FRAC_BITS);
		v = round_half_up((FRAC_ONE - fy) * a + fy * b, 2 * FRAC_BITS);
		r.noise = sat_q14(v);
		return r;
	endfunction

	// called on every accepted item, in acceptance order
	task automatic take_item();
		int idx;
		if (mode == MODE_WRITE) begin
			idx = int'(grad_row) * DEF_GRID_COLUMNS + int'(grad_column);
			grad_x_tab[idx] = sat_q14(grad_x);
			grad_y_tab[idx] = sat_q14(grad_y);
			writes_done++;
		end else begin
			noise_expected.push_back(predict_noise(x_coord, y_coord));
		end
	endtask

	task automatic report_mismatch(string what);
		if (fail_count < PRINT_CAP)
			$display("MISMATCH @%0t: %s", $realtime, what);
		fail_count++;
	endtask

	// ------------------------------------------------------------------
	// Driver: one item per handshake, random idle cycles between items
	// ------------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_hold  <= 0;
		end else begin
			if (in_valid && in_ready)
				take_item();
			if (!in_valid || in_ready) begin
				if (in_hold != 0) begin
					in_hold  <= in_hold - 1;
					in_valid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					next_item    = pending_items.pop_front();
					mode        <= next_item.mode;
					x_coord     <= next_item.x;
					y_coord     <= next_item.y;
					grad_column <= next_item.col;
					grad_row    <= next_item.row;
					grad_x      <= next_item.gx;
					grad_y      <= next_item.gy;
					in_valid    <= 1'b1;
					in_hold     <= steady_in ? 0 : $urandom_range(0, MAX_IDLE);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: random back-pressure, in-order compare
	// ------------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_hold  <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (noise_expected.size() == 0) begin
					report_mismatch($sformatf("unexpected item noise=%0d clamped=%0b",
						noise_value, point_clamped));
				end else begin
					if (noise_value !== noise_expected[0].noise)
						report_mismatch($sformatf("noise_value got %0d want %0d",
							noise_value, noise_expected[0].noise));
					if (point_clamped !== noise_expected[0].clamped)
						report_mismatch($sformatf("point_clamped got %0b want %0b",
							point_clamped, noise_expected[0].clamped));
					void'(noise_expected.pop_front());
				end
				evals_seen++;
				out_draw = steady_out ? 0 : $urandom_range(0, MAX_IDLE);
				out_ready <= (out_draw == 0);
				out_hold  <= out_draw;
			end else if (!out_ready) begin
				if (out_hold > 1)
					out_hold <= out_hold - 1;
				else
					out_ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	task automatic push_write(int col, int row, logic signed [GRAD_W-1:0] gx,
			logic signed [GRAD_W-1:0] gy);
		sampler_item_t it;
		it.mode = MODE_WRITE;
		it.x    = COORD_W'($urandom);
		it.y    = COORD_W'($urandom);
		it.col  = IDX_IN_W'(col);
		it.row  = IDX_IN_W'(row);
		it.gx   = gx;
		it.gy   = gy;
		pending_items.push_back(it);
	endtask

	task automatic push_eval(int x, int y);
		sampler_item_t it;
		it.mode = MODE_EVAL;
		it.x    = COORD_W'(x);
		it.y    = COORD_W'(y);
		// unused fields carry noise
		it.col  = IDX_IN_W'($urandom);
		it.row  = IDX_IN_W'($urandom);
		it.gx   = GRAD_W'($urandom);
		it.gy   = GRAD_W'($urandom);
		pending_items.push_back(it);
	endtask

	// mostly legal Q1.14, sometimes any 16-bit pattern (exercises saturation)
	function automatic logic signed [GRAD_W-1:0] rand_grad();
		if ($urandom_range(0, 4) == 0)
			return GRAD_W'($urandom);
		return GRAD_W'(int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE);
	endfunction

	// lim is the last unclamped coordinate for the current grid
	function automatic int rand_coord(int lim);
		int pick;
		pick = $urandom_range(0, 19);
		if (pick < 12)
			return $urandom_range(0, lim);
		if (pick < 15)
			return $urandom_range(0, lim >> FRAC_BITS) << FRAC_BITS;   // on a corner
		if (pick == 15)
			return lim;                                                  // last edge
		return $urandom_range(0, (1 << COORD_W) - 1);                    // often clamped
	endfunction

	// wait until the sender is empty and every expected result has come back
	task automatic wait_drained();
		while (pending_items.size() != 0 || in_valid || noise_expected.size() != 0)
			@(posedge clk);
		repeat (PIPE_SETTLE) @(posedge clk);
	endtask

	// width then height, valid held high across both writes
	task automatic set_grid(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_GRID_WIDTH;
		cfg_data  <= w;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		grid_w_reg = w;
		cfg_index <= CFG_GRID_HEIGHT;
		cfg_data  <= h;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		grid_h_reg = h;
		cfg_valid <= 1'b0;
		grid_count++;
		@(posedge clk);
	endtask

	// grid plans: extremes, in-range values and out-of-range register values
	logic [SIZE_W-1:0] plan_w [8] = '{5'd2, 5'd31, 5'd5, 5'd1, 5'd16, 5'd3, 5'd16, 5'd9};
	logic [SIZE_W-1:0] plan_h [8] = '{5'd2, 5'd0, 5'd9, 5'd17, 5'd2, 5'd16, 5'd16, 5'd12};

	initial begin
		int xl, yl;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		grid_count = 1;   // reset grid 16x16

		// the table has no reset, so every entry is loaded before any read
		for (int r = 0; r < DEF_GRID_ROWS; r++)
			for (int c = 0; c < DEF_GRID_COLUMNS; c++)
				push_write(c, r, rand_grad(), rand_grad());

		// directed part, reset grid 16x16
		push_eval(0, 0);
		push_eval(3840, 3840);          // last corner, far corners fold back
		push_eval(4095, 4095);          // clamped on both axes
		push_eval(3841, 0);             // clamped in x only
		push_eval(0, 3841);             // clamped in y only
		push_eval(255, 255);            // largest fraction
		push_eval(128, 128);            // half-cell, rounding ties
		push_write(0, 0, 16'sh7fff, -16'sh8000);      // saturates both components
		push_write(1, 0, 16'sd16384, -16'sd16384);
		push_write(0, 1, -16'sd16385, 16'sd16385);    // just beyond one
		push_write(1, 1, 16'sd0, -16'sd1);
		push_eval(64, 192);
		push_eval(200, 50);
		push_eval(256, 256);
		push_write(15, 15, 16'sd16384, 16'sd16384);
		push_write(15, 0, -16'sd16384, -16'sd16384);
		push_write(0, 15, 16'sd16384, -16'sd16384);
		push_eval(3840, 0);
		push_eval(0, 3840);
		push_eval(3839, 3839);
		push_eval(3820, 4000);
		push_eval(4095, 0);

		// sender holds back here until everything is back
		wait_drained();

		// random phases, one per grid plan
		for (int p = 0; p < 8; p++) begin
			set_grid(plan_w[p], plan_h[p]);
			steady_in  = (p == 0) ? 1'b1 : ($urandom_range(0, 3) == 0);
			steady_out = (p == 0) ? 1'b1 : ($urandom_range(0, 3) == 0);
			xl = (eff_size(grid_w_reg, DEF_GRID_COLUMNS) - 1) << FRAC_BITS;
			yl = (eff_size(grid_h_reg, DEF_GRID_ROWS) - 1) << FRAC_BITS;
			for (int n = 0; n < 60; n++) begin
				if ($urandom_range(0, 3) == 0)
					push_write($urandom_range(0, DEF_GRID_COLUMNS - 1),
						$urandom_range(0, DEF_GRID_ROWS - 1), rand_grad(), rand_grad());
				else
					push_eval(rand_coord(xl), rand_coord(yl));
			end
			wait_drained();
		end

		$display("run: %0d noise results checked, %0d gradient writes, %0d grid sizes",
			evals_seen, writes_done, grid_count);
		$display("run: clamped points, last-edge cells and saturated gradients included");
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
